### design/steq_pkg.sv
// ----------------------------------------------------------------------------
// steq_pkg
// Shared types and constants for the sorted timer event queue.
// ----------------------------------------------------------------------------
package steq_pkg;

  localparam int unsigned TIME_W      = 32;
  localparam int unsigned ID_W        = 16;
  localparam int unsigned ENTRY_W     = TIME_W + ID_W;
  // most entries popped by one tick
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned NFIRE_W     = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_DEL  = 2'd1,
    OP_CLR  = 2'd2,
    OP_TICK = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_FIRED    = 3'd1,
    ST_NOTHING  = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0] fired_id;
    status_t         status;
    logic            last;
  } result_t;

endpackage

### design/sorted_timer_event_queue.sv
// ----------------------------------------------------------------------------
// sorted_timer_event_queue
// Time-ordered queue of pending events with add, delete, clear and tick.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  in      | in_valid / in_ready | op, timeout, event_id, game_time,
//          |                     | clock_stopped
//  out     | out_valid/out_ready | fired_id, status, last
//
//  One item at a time; in_ready is high only while the sequencer is idle.
//  RAM with registered read: each entry is read (RD state), then compared
//  (EV state). Add scans down from the tail, moving later entries up one slot,
//  and stops at an earlier entry; delete scans every held entry; clear, full
//  add and stopped tick answer without a scan; tick pops due entries from the head.
//  Reset empties the queue at once. A result waiting in the output register
//  holds the sequencer only when the next result is ready to go.
// ----------------------------------------------------------------------------
module sorted_timer_event_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  op,
  input  logic [steq_pkg::TIME_W-1:0] timeout,
  input  logic [steq_pkg::ID_W-1:0]   event_id,
  input  logic [steq_pkg::TIME_W-1:0] game_time,
  input  logic                        clock_stopped,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [steq_pkg::ID_W-1:0]   fired_id,
  output logic [2:0]                  status,
  output logic                        last
);

  logic              idle;
  logic              emit;
  logic              slot_free;
  steq_pkg::result_t result;

  assign in_ready  = idle;
  assign slot_free = !out_valid || out_ready;

  steq_seq #(
    .DEPTH(DEPTH)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (in_valid && in_ready),
    .op           (op),
    .timeout      (timeout),
    .event_id     (event_id),
    .game_time    (game_time),
    .clock_stopped(clock_stopped),
    .slot_free    (slot_free),
    .idle         (idle),
    .emit         (emit),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      fired_id <= result.fired_id;
      status   <= result.status;
      last     <= result.last;
    end
  end

endmodule

### design/steq_ram.sv
// ----------------------------------------------------------------------------
// steq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module steq_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/steq_cmp.sv
// ----------------------------------------------------------------------------
// steq_cmp
// Shared 32-bit unsigned compare unit: less-or-equal and equality.
// ----------------------------------------------------------------------------
module steq_cmp (
  input  logic [steq_pkg::TIME_W-1:0] a,
  input  logic [steq_pkg::TIME_W-1:0] b,
  output logic                        le,
  output logic                        eq
);

  assign le = (a <= b);
  assign eq = (a == b);

endmodule

### design/steq_seq.sv
// ----------------------------------------------------------------------------
// steq_seq
// Queue sequencer: circular entry store, one entry read per step, scanned
// through the shared compare unit for insert, delete and tick.
// ----------------------------------------------------------------------------
module steq_seq #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [1:0]                    op,
  input  logic [steq_pkg::TIME_W-1:0]   timeout,
  input  logic [steq_pkg::ID_W-1:0]     event_id,
  input  logic [steq_pkg::TIME_W-1:0]   game_time,
  input  logic                          clock_stopped,
  input  logic                          slot_free,
  output logic                          idle,
  output logic                          emit,
  output steq_pkg::result_t             result
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [steq_pkg::NFIRE_W-1:0] MAX_N =
    steq_pkg::NFIRE_W'(steq_pkg::MAX_RESULTS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_EV,
    S_ADD_PUT,
    S_DEL_RD,
    S_DEL_EV,
    S_TICK_RD,
    S_TICK_EV,
    S_TICK_END,
    S_EMIT
  } state_t;

  state_t                           state;
  logic [CW-1:0]                    cnt;
  logic [AW-1:0]                    head;
  logic [CW-1:0]                    idx;
  logic [steq_pkg::NFIRE_W-1:0]     nfired;
  logic                             found;
  logic                             pend_valid;
  logic [steq_pkg::ID_W-1:0]        pend_id;
  logic [steq_pkg::ID_W-1:0]        req_id;
  logic [steq_pkg::TIME_W-1:0]      req_t;
  logic [steq_pkg::TIME_W-1:0]      req_now;
  steq_pkg::result_t                res;

  logic                             we;
  logic [AW-1:0]                    waddr;
  logic [steq_pkg::ENTRY_W-1:0]     wdata;
  logic [AW-1:0]                    raddr;
  logic [steq_pkg::ENTRY_W-1:0]     rdata;
  logic [steq_pkg::TIME_W-1:0]      rd_due;
  logic [steq_pkg::ID_W-1:0]        rd_id;
  logic [steq_pkg::TIME_W-1:0]      cmp_a;
  logic [steq_pkg::TIME_W-1:0]      cmp_b;
  logic                             cmp_le;
  logic                             cmp_eq;
  logic [CW-1:0]                    idx_dec;
  logic [CW-1:0]                    idx_inc;
  logic                             found_now;

  // logical slot to physical address, wrapping at DEPTH
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  assign rd_due    = rdata[steq_pkg::ENTRY_W-1:steq_pkg::ID_W];
  assign rd_id     = rdata[steq_pkg::ID_W-1:0];
  assign idx_dec   = idx - CW'(1);
  assign idx_inc   = idx + CW'(1);
  assign found_now = found | cmp_eq;
  assign idle      = (state == S_IDLE);
  assign emit      = (state == S_EMIT) && slot_free;
  assign result    = res;

  steq_ram #(
    .WIDTH(steq_pkg::ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  steq_cmp u_cmp (
    .a (cmp_a),
    .b (cmp_b),
    .le(cmp_le),
    .eq(cmp_eq)
  );

  always_comb begin
    cmp_a = rd_due;
    cmp_b = req_now;
    raddr = head;
    we    = 1'b0;
    waddr = wrap_add(head, idx[AW-1:0]);
    wdata = rdata;
    case (state)
      S_ADD_RD: begin
        raddr = wrap_add(head, idx_dec[AW-1:0]);
      end
      S_ADD_EV: begin
        cmp_a = req_t;
        cmp_b = rd_due;
        // entry moves up one slot to open the gap
        we    = cmp_le;
      end
      S_ADD_PUT: begin
        we    = 1'b1;
        wdata = {req_t, req_id};
      end
      S_DEL_RD: begin
        raddr = wrap_add(head, idx[AW-1:0]);
      end
      S_DEL_EV: begin
        cmp_a = {{(steq_pkg::TIME_W - steq_pkg::ID_W){1'b0}}, rd_id};
        cmp_b = {{(steq_pkg::TIME_W - steq_pkg::ID_W){1'b0}}, req_id};
        // past the removed entry, close the gap
        we    = found;
        waddr = wrap_add(head, idx_dec[AW-1:0]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      head       <= '0;
      idx        <= '0;
      nfired     <= '0;
      found      <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            req_id  <= event_id;
            req_t   <= game_time + timeout;
            req_now <= game_time;
            case (op)
              steq_pkg::OP_ADD: begin
                if (cnt == DEPTH_C) begin
                  res   <= '{fired_id: '0, status: steq_pkg::ST_FULL, last: 1'b1};
                  state <= S_EMIT;
                end else begin
                  idx   <= cnt;
                  state <= (cnt == '0) ? S_ADD_PUT : S_ADD_RD;
                end
              end
              steq_pkg::OP_DEL: begin
                idx   <= '0;
                found <= 1'b0;
                if (cnt == '0) begin
                  res   <= '{fired_id: '0, status: steq_pkg::ST_NOTFOUND, last: 1'b1};
                  state <= S_EMIT;
                end else begin
                  state <= S_DEL_RD;
                end
              end
              steq_pkg::OP_CLR: begin
                cnt   <= '0;
                head  <= '0;
                res   <= '{fired_id: '0, status: steq_pkg::ST_DONE, last: 1'b1};
                state <= S_EMIT;
              end
              steq_pkg::OP_TICK: begin
                nfired     <= '0;
                pend_valid <= 1'b0;
                if (clock_stopped) begin
                  res   <= '{fired_id: '0, status: steq_pkg::ST_NOTHING, last: 1'b1};
                  state <= S_EMIT;
                end else begin
                  state <= S_TICK_RD;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_ADD_RD: begin
          state <= S_ADD_EV;
        end
        S_ADD_EV: begin
          if (cmp_le) begin
            idx   <= idx_dec;
            state <= (idx == CW'(1)) ? S_ADD_PUT : S_ADD_RD;
          end else begin
            state <= S_ADD_PUT;
          end
        end
        S_ADD_PUT: begin
          cnt   <= cnt + CW'(1);
          res   <= '{fired_id: '0, status: steq_pkg::ST_DONE, last: 1'b1};
          state <= S_EMIT;
        end
        S_DEL_RD: begin
          state <= S_DEL_EV;
        end
        S_DEL_EV: begin
          found <= found_now;
          idx   <= idx_inc;
          if (idx_inc == cnt) begin
            if (found_now) begin
              cnt <= cnt - CW'(1);
              res <= '{fired_id: '0, status: steq_pkg::ST_DONE, last: 1'b1};
            end else begin
              res <= '{fired_id: '0, status: steq_pkg::ST_NOTFOUND, last: 1'b1};
            end
            state <= S_EMIT;
          end else begin
            state <= S_DEL_RD;
          end
        end
        S_TICK_RD: begin
          if ((cnt == '0) || (nfired == MAX_N)) begin
            state <= S_TICK_END;
          end else begin
            state <= S_TICK_EV;
          end
        end
        S_TICK_EV: begin
          if (cmp_le) begin
            if (pend_valid) begin
              // flush the held entry first; head is read again afterwards
              res        <= '{fired_id: pend_id, status: steq_pkg::ST_FIRED, last: 1'b0};
              pend_valid <= 1'b0;
              state      <= S_EMIT;
            end else begin
              pend_id    <= rd_id;
              pend_valid <= 1'b1;
              head       <= wrap_add(head, AW'(1));
              cnt        <= cnt - CW'(1);
              nfired     <= nfired + steq_pkg::NFIRE_W'(1);
              state      <= S_TICK_RD;
            end
          end else begin
            state <= S_TICK_END;
          end
        end
        S_TICK_END: begin
          if (pend_valid) begin
            res <= '{fired_id: pend_id, status: steq_pkg::ST_FIRED, last: 1'b1};
          end else begin
            res <= '{fired_id: '0, status: steq_pkg::ST_NOTHING, last: 1'b1};
          end
          pend_valid <= 1'b0;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            state <= res.last ? S_IDLE : S_TICK_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
